// File: sv/tofw_pkg.sv
// Package for the time-of-flight window range filter.
// Holds operation codes, word widths and the fixed filter constants.
// No dependencies.
package tofw_pkg;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int TICK_W     = 16;
   localparam int NODE_W     = 16;
   localparam int DIST_W     = 9;

   localparam logic       OP_STORE = 1'b0;
   localparam logic       OP_CLEAR = 1'b1;

   localparam logic [TICK_W-1:0] NO_SECOND = 16'hFFFF;
   localparam logic [TICK_W-1:0] BOUND_MUL = 16'd13;
   localparam logic [TICK_W-1:0] BOUND_SUB = 16'd3776;
   localparam logic [TICK_W-1:0] DIST_MUL  = 16'd9;
   localparam logic [DIST_W-1:0] DIST_ADD  = 9'd9;

endpackage

// File: sv/tof_window_range_filter_unit.sv
// Time-of-flight window range filter, top level.
// Depends on tofw_pkg.
//
// channel | dir | words
// req     | in  | tuser = operation; tdata = flight_ticks, source_id
// rsp     | out | tdata = source_node, distance_cm, zero fill
//
// A store or clear word is accepted only in ST_IDLE. A window-completing store
// starts two walks of one shared compare over the window, then a bound state
// and a scale state, before rsp_tvalid. After such a store, req_tready is low
// from acceptance until the result word is taken. Reset zeros the window and
// the write slot. A stalled rsp holds its word and the block.
module tof_window_range_filter_unit #(
   parameter int WINDOW_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_tuser,  // operation
   input  logic [tofw_pkg::REQ_DATA_W-1:0] req_tdata, // flight_ticks, source_id
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tofw_pkg::RSP_DATA_W-1:0] rsp_tdata  // source_node, distance_cm, zeros
);
   import tofw_pkg::*;

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MIN, ST_SECOND, ST_BOUND, ST_SCALE, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [TICK_W-1:0] window_ff [WINDOW_DEPTH];
   logic [TICK_W-1:0] window_in [WINDOW_DEPTH];
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TICK_W-1:0] m1_ff, m1_in;
   logic [TICK_W-1:0] m2_ff, m2_in;
   logic [TICK_W-1:0] pick_ff, pick_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [TICK_W-1:0] cand;
   logic [TICK_W-1:0] best;
   logic              take;
   logic [TICK_W-1:0] bound;
   logic [TICK_W-1:0] scaled;
   logic              accept;

   assign accept = req_tvalid && req_tready;
   assign cand   = window_ff[idx_ff];

   // shared compare unit
   always_comb begin
      best = (state_ff == ST_SECOND) ? m2_ff : m1_ff;
      take = (cand < best) && ((state_ff != ST_SECOND) || (cand != m1_ff));
   end

   assign bound  = TICK_W'({4'b0, m2_ff[TICK_W-1:4]} * BOUND_MUL) - BOUND_SUB;
   assign scaled = TICK_W'({4'b0, pick_ff[TICK_W-1:4]} * DIST_MUL);

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      pick_in      = pick_ff;
      node_in      = node_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_CLEAR) begin
                  for (int k = 0; k < WINDOW_DEPTH; k++) begin
                     window_in[k] = '0;
                  end
               end else begin
                  window_in[slot_ff] = req_tdata[TICK_W-1:0];
                  node_in            = req_tdata[TICK_W +: NODE_W];
                  if (slot_ff == LAST_IDX) begin
                     slot_in  = '0;
                     idx_in   = '0;
                     m1_in    = NO_SECOND;
                     m2_in    = NO_SECOND;
                     state_in = ST_MIN;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end
            end
         end
         ST_MIN: begin
            if (take) begin
               m1_in = cand;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_SECOND;
            end
         end
         ST_SECOND: begin
            if (take) begin
               m2_in = cand;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            pick_in  = (m1_ff < bound) ? m2_ff : m1_ff;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            dist_in      = scaled[TICK_W-1:7] + DIST_ADD;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      pick_ff <= pick_in;
      node_ff <= node_in;
      dist_ff <= dist_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - NODE_W - DIST_W)'(0), dist_ff, node_ff};

endmodule
